### hw/rtl/ccsb_pkg.sv
// Shared types, constants and helpers of the character-class span/break matcher.
package ccsb_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CLASS_W    = 256;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    MODE_SPAN   = 2'd0,
    MODE_BREAK  = 2'd1,
    MODE_ANY    = 2'd2,
    MODE_NOTANY = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS0   = 3'd0,
    REG_CLASS1   = 3'd1,
    REG_CLASS2   = 3'd2,
    REG_CLASS3   = 3'd3,
    REG_MODE     = 3'd4,
    REG_ANCHORED = 3'd5,
    REG_BASE     = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_RUN    = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [CLASS_W-1:0] member_map;
    mode_e              mode;
    logic               anchored;
    logic [POS_W-1:0]   base;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_begin;
    logic [POS_W-1:0] match_finish;
  } res_t;

  // base plus relative position, saturating at the top of the position range
  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] base,
                                               input logic [POS_W-1:0] rel);
    logic [POS_W:0] sum;
    sum = {1'b0, base} + {1'b0, rel};
    return sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
  endfunction

endpackage

### hw/rtl/ccsb_if.sv
// Handshake channel interfaces: subject bytes in, match results out, register writes.
interface ccsb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] subject_byte;
  logic       last_byte;
  modport source(output valid, subject_byte, last_byte, input ready);
  modport sink(input valid, subject_byte, last_byte, output ready);
endinterface

interface ccsb_out_if import ccsb_pkg::*;;
  logic             valid;
  logic             ready;
  logic             match_found;
  logic [POS_W-1:0] match_begin;
  logic [POS_W-1:0] match_finish;
  modport source(output valid, match_found, match_begin, match_finish, input ready);
  modport sink(input valid, match_found, match_begin, match_finish, output ready);
endinterface

interface ccsb_cfg_if import ccsb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/ccsb_core.sv
// Per-byte scan state and match decision for one subject byte.
module ccsb_core import ccsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output logic       emit_o,
  output res_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] run_q, run_d;

  logic             member, hit, found;
  logic [POS_W-1:0] nxt, beg, fin;

  always_comb begin
    member  = cfg_i.member_map[byte_i];
    hit     = (cfg_i.mode == MODE_NOTANY) ? !member : member;
    nxt     = (pos_q == POS_MAX) ? POS_MAX : pos_q + POS_W'(1);
    phase_d = phase_q;
    run_d   = run_q;
    emit_o  = 1'b0;
    found   = 1'b0;
    beg     = '0;
    fin     = '0;

    unique case (phase_q)
      PH_SEARCH: begin
        unique case (cfg_i.mode)
          MODE_SPAN: begin
            if (member) begin
              if (last_i) begin
                emit_o = 1'b1; found = 1'b1; beg = pos_q; fin = nxt;
              end else begin
                phase_d = PH_RUN;
                run_d   = pos_q;
              end
            end else if (cfg_i.anchored) begin
              emit_o  = 1'b1;
              phase_d = PH_DONE;
            end
          end
          MODE_BREAK: begin
            if (member) begin
              emit_o = 1'b1; found = 1'b1; beg = '0; fin = pos_q;
              phase_d = PH_DONE;
            end
          end
          MODE_ANY, MODE_NOTANY: begin
            if (hit) begin
              emit_o = 1'b1; found = 1'b1; beg = pos_q; fin = nxt;
              phase_d = PH_DONE;
            end else if (cfg_i.anchored) begin
              emit_o  = 1'b1;
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      PH_RUN: begin
        if (!member) begin
          emit_o = 1'b1; found = 1'b1; beg = run_q; fin = pos_q;
          phase_d = PH_DONE;
        end else if (last_i) begin
          emit_o = 1'b1; found = 1'b1; beg = run_q; fin = nxt;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // subject over with nothing reported: no match
    if (last_i && !emit_o && phase_d == PH_SEARCH) begin
      emit_o = 1'b1;
    end

    if (last_i) begin
      phase_d = PH_SEARCH;
      pos_d   = '0;
      run_d   = '0;
    end else begin
      pos_d   = nxt;
    end

    res_o.found        = found;
    res_o.match_begin  = found ? sat_add(cfg_i.base, beg) : '0;
    res_o.match_finish = found ? sat_add(cfg_i.base, fin) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      pos_q   <= '0;
      run_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      run_q   <= run_d;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("scan phase not one-hot");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> phase_q == PH_SEARCH && pos_q == '0 && run_q == '0)
    else $error("scan state not cleared after last item");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_DONE |-> !emit_o)
    else $error("second result in one subject");

  a_pos_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && pos_q != POS_MAX |=> pos_q == $past(pos_q) + POS_W'(1))
    else $error("position counter skipped");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && res_o.found |-> res_o.match_begin <= res_o.match_finish)
    else $error("match finishes before it begins");

endmodule

### hw/rtl/char_class_span_break_matcher.sv
// Top level of the character-class span/break/any/notany matcher.
// Takes one subject byte per cycle on in_i while the result buffer has room, and
// gives one result item on out_o per subject: the first match of the class
// pattern, or no match. The byte passes an input register and the scan logic,
// and its result goes into a two-entry result buffer that keeps input flowing
// while out_o is stalled, until it is full. Registers on cfg_i are taken in every
// cycle and are to be written only while no subject is in flight.
module char_class_span_break_matcher import ccsb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccsb_in_if.sink    in_i,
  ccsb_cfg_if.sink   cfg_i,
  ccsb_out_if.source out_o
);

  cfg_t       cfg_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  res_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  logic       space, step, emit, push, pop;
  res_t       res;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.member_map <= '0;
      cfg_q.mode       <= MODE_SPAN;
      cfg_q.anchored   <= 1'b0;
      cfg_q.base       <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_CLASS0:   cfg_q.member_map[0*WORD_W +: WORD_W] <= cfg_i.data;
        REG_CLASS1:   cfg_q.member_map[1*WORD_W +: WORD_W] <= cfg_i.data;
        REG_CLASS2:   cfg_q.member_map[2*WORD_W +: WORD_W] <= cfg_i.data;
        REG_CLASS3:   cfg_q.member_map[3*WORD_W +: WORD_W] <= cfg_i.data;
        REG_MODE:     cfg_q.mode     <= mode_e'(cfg_i.data[1:0]);
        REG_ANCHORED: cfg_q.anchored <= cfg_i.data[0];
        REG_BASE:     cfg_q.base     <= cfg_i.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign space      = (cnt_q != 2'd2);
  assign step       = s1_valid_q && space;
  assign in_i.ready = !s1_valid_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.subject_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  ccsb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg_q),
    .emit_o (emit),
    .res_o  (res)
  );

  // result buffer
  assign push = step && emit;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= res;
  end

  assign out_o.valid        = (cnt_q != 2'd0);
  assign out_o.match_found  = buf_q[rd_ptr_q].found;
  assign out_o.match_begin  = buf_q[rd_ptr_q].match_begin;
  assign out_o.match_finish = buf_q[rd_ptr_q].match_finish;

  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result buffer overfilled");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("result written into full buffer");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("buffer pointers disagree with fill count");

endmodule
